/* design/snau_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// snau_pkg
// Shared types and constants of the spiking neuron array update block.
// ----------------------------------------------------------------------------
package snau_pkg;

    localparam int NEIGHBORS = 32;
    localparam int SIDE_W    = $clog2(NEIGHBORS);
    localparam int IDX_EXT_W = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    localparam logic [1:0] OP_SETUP  = 2'd0;
    localparam logic [1:0] OP_STIM   = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRE_POT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFR     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COOL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd4;

    localparam logic signed [23:0] LEVEL_CAP = 24'sd65280;
    localparam logic signed [23:0] LEVEL_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] LEVEL_MIN = 24'sh800000;
    localparam logic [17:0]        THR_MAX   = 18'h3FFFF;

    typedef struct packed {
        logic signed [23:0] level;
        logic [15:0]        potential;
        logic [7:0]         refr;
        logic               active;
        logic               high;
    } snau_dyn_t;

    typedef struct packed {
        logic [17:0] threshold;
        logic [31:0] route;
        logic [31:0] axon;
    } snau_setup_t;

    typedef struct packed {
        logic clr;
        logic take;
        logic exec;
    } snau_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic need_out;
        logic out_busy;
    } snau_status_t;

endpackage
`default_nettype wire

/* design/snau_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// snau_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module snau_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

/* design/snau_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// snau_ctrl
// Controller: clearing pass after reset, then read and execute per item.
// ----------------------------------------------------------------------------
module snau_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire snau_pkg::snau_status_t status,
    output snau_pkg::snau_cmd_t        cmd
);
    import snau_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold while the previous result waits
                if (!(status.need_out && status.out_busy))
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

/* design/snau_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// snau_datapath
// Neuron memories, configuration registers, update arithmetic, result register.
// ----------------------------------------------------------------------------
module snau_datapath #(
    parameter int NODES = 1024
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire snau_pkg::snau_cmd_t            cmd,
    output snau_pkg::snau_status_t              status,
    input  wire logic                           cfg_we,
    input  wire logic [snau_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [snau_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic [1:0]                     op,
    input  wire logic [9:0]                     node_index,
    input  wire logic signed [23:0]             value,
    input  wire logic [31:0]                    route_path,
    input  wire logic [31:0]                    route_axon,
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output logic                                fired,
    output logic [snau_pkg::SIDE_W-1:0]         neighbor_side,
    output logic [31-snau_pkg::SIDE_W:0]        forward_path,
    output logic [31:0]                         forward_axon,
    output logic [23:0]                         forward_weight,
    output logic                                too_high
);
    import snau_pkg::*;

    localparam int AW = $clog2(NODES);

    // configuration
    logic [15:0] fire_pot_reg;
    logic [7:0]  refr_ticks_reg;
    logic [15:0] cool_reg;
    logic [15:0] gain_reg;
    logic        mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fire_pot_reg   <= 16'd25600;
            refr_ticks_reg <= 8'd2;
            cool_reg       <= 16'd32768;
            gain_reg       <= 16'd256;
            mode_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIRE_POT: fire_pot_reg   <= cfg_data;
                CFG_REFR:     refr_ticks_reg <= cfg_data[7:0];
                CFG_COOL:     cool_reg       <= cfg_data;
                CFG_GAIN:     gain_reg       <= cfg_data;
                CFG_MODE:     mode_reg       <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // clearing pass counter
    logic [AW-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // item latched on transfer
    logic [1:0]            op_reg;
    logic [AW-1:0]         addr_reg;
    logic                  hit_reg;
    logic signed [23:0]    val_reg;
    logic [31:0]           route_reg;
    logic [31:0]           axon_reg;
    logic [IDX_EXT_W-1:0]  idx_ext;
    logic [AW-1:0]         rd_addr;

    assign idx_ext = IDX_EXT_W'(node_index);
    assign rd_addr = idx_ext[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg    <= op;
            addr_reg  <= rd_addr;
            hit_reg   <= idx_ext < IDX_EXT_W'(NODES);
            val_reg   <= value;
            route_reg <= route_path;
            axon_reg  <= route_axon;
        end
    end

    // memories
    snau_dyn_t   rd_dyn;
    snau_setup_t rd_setup;
    snau_dyn_t   wr_dyn;
    snau_dyn_t   new_dyn;
    snau_setup_t new_setup;
    logic        dyn_we;
    logic        setup_we;
    logic [AW-1:0] dyn_waddr;

    assign dyn_we    = cmd.clr ||
                       (cmd.exec && hit_reg && (op_reg == OP_STIM || op_reg == OP_UPDATE));
    assign setup_we  = cmd.exec && hit_reg && (op_reg == OP_SETUP);
    assign dyn_waddr = cmd.clr ? clr_cnt_reg : addr_reg;
    assign wr_dyn    = cmd.clr ? snau_dyn_t'('0) : new_dyn;

    snau_ram #(
        .WIDTH ($bits(snau_dyn_t)),
        .DEPTH (NODES)
    ) u_dyn_ram (
        .clk   (clk),
        .we    (dyn_we),
        .waddr (dyn_waddr),
        .wdata (wr_dyn),
        .re    (cmd.take),
        .raddr (rd_addr),
        .rdata (rd_dyn)
    );

    snau_ram #(
        .WIDTH ($bits(snau_setup_t)),
        .DEPTH (NODES)
    ) u_setup_ram (
        .clk   (clk),
        .we    (setup_we),
        .waddr (addr_reg),
        .wdata (new_setup),
        .re    (cmd.take),
        .raddr (rd_addr),
        .rdata (rd_setup)
    );

    // arithmetic
    logic signed [23:0] lvl_cap;
    logic               refr_zero;
    logic               fire;
    logic [15:0]        pot1;
    logic               act1;
    logic [7:0]         refr1;
    logic [15:0]        lvl_pos;
    logic [23:0]        lvl_mag;
    logic [23:0]        mul_a;
    logic [39:0]        lvl_prod;
    logic [23:0]        lvl_dec;
    logic [31:0]        pot_prod;
    logic [31:0]        wgt_prod;
    logic [20:0]        lvl_x5;
    logic [20:0]        thr_x6;
    logic               high;
    logic signed [24:0] stim_sum;
    logic signed [23:0] stim_lvl;

    always_comb
    begin
        lvl_cap   = (rd_dyn.level > LEVEL_CAP) ? LEVEL_CAP : rd_dyn.level;
        refr_zero = (rd_dyn.refr == 8'd0);
        fire      = !lvl_cap[23] && refr_zero &&
                    ({6'd0, rd_setup.threshold} <= $unsigned(lvl_cap));
        pot1      = fire ? fire_pot_reg : rd_dyn.potential;
        act1      = fire ? 1'b1 : (refr_zero ? 1'b0 : rd_dyn.active);
        refr1     = fire ? refr_ticks_reg : rd_dyn.refr;
        lvl_pos   = lvl_cap[23] ? 16'd0 : lvl_cap[15:0];
        lvl_mag   = rd_dyn.level[23] ? (24'd0 - $unsigned(rd_dyn.level))
                                     : $unsigned(rd_dyn.level);
        mul_a     = mode_reg ? lvl_mag : {8'd0, lvl_pos};
        lvl_prod  = {16'd0, mul_a} * {24'd0, cool_reg};
        lvl_dec   = lvl_prod[39:16];
        pot_prod  = {16'd0, pot1} * {16'd0, cool_reg};
        wgt_prod  = {16'd0, pot1} * {16'd0, gain_reg};
        lvl_x5    = {3'd0, lvl_pos, 2'b00} + {5'd0, lvl_pos};
        thr_x6    = {1'b0, rd_setup.threshold, 2'b00} + {2'b00, rd_setup.threshold, 1'b0};
        high      = lvl_x5 > thr_x6;
        stim_sum  = {rd_dyn.level[23], rd_dyn.level} + {val_reg[23], val_reg};
        if (stim_sum[24] != stim_sum[23])
        begin
            stim_lvl = stim_sum[24] ? LEVEL_MIN : LEVEL_MAX;
        end
        else
        begin
            stim_lvl = stim_sum[23:0];
        end

        new_dyn = rd_dyn;
        case (op_reg)
            OP_STIM:
            begin
                new_dyn.level = stim_lvl;
            end
            OP_UPDATE:
            begin
                if (mode_reg)
                begin
                    new_dyn.level = rd_dyn.level[23] ? $signed(24'd0 - lvl_dec)
                                                     : $signed(lvl_dec);
                end
                else
                begin
                    new_dyn.level     = $signed(lvl_dec);
                    new_dyn.potential = pot_prod[31:16];
                    new_dyn.refr      = (refr1 != 8'd0) ? refr1 - 8'd1 : 8'd0;
                    new_dyn.active    = act1;
                    new_dyn.high      = high;
                end
            end
            default:
            begin
                new_dyn = rd_dyn;
            end
        endcase

        new_setup.threshold = val_reg[23] ? 18'd0
                            : ((|val_reg[22:18]) ? THR_MAX : val_reg[17:0]);
        new_setup.route     = route_reg;
        new_setup.axon      = axon_reg;
    end

    // result register
    logic                        load_out;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        fired_reg;
    logic [SIDE_W-1:0]           side_reg;
    logic [31-SIDE_W:0]          path_reg;
    logic [31:0]                 axon_out_reg;
    logic [23:0]                 weight_reg;
    logic                        high_reg;
    logic                        send;

    assign load_out = cmd.exec && hit_reg && (op_reg == OP_UPDATE);
    assign send     = load_out && !mode_reg && act1;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            fired_reg    <= send;
            side_reg     <= send ? rd_setup.route[SIDE_W-1:0] : '0;
            path_reg     <= send ? rd_setup.route[31:SIDE_W] : '0;
            axon_out_reg <= send ? rd_setup.axon : 32'd0;
            weight_reg   <= send ? wgt_prod[31:8] : 24'd0;
            high_reg     <= mode_reg ? rd_dyn.high : high;
        end
    end

    assign result_valid    = out_valid_reg;
    assign fired           = fired_reg;
    assign neighbor_side   = side_reg;
    assign forward_path    = path_reg;
    assign forward_axon    = axon_out_reg;
    assign forward_weight  = weight_reg;
    assign too_high        = high_reg;

    assign status.clr_last = (clr_cnt_reg == AW'(NODES - 1));
    assign status.need_out = hit_reg && (op_reg == OP_UPDATE);
    assign status.out_busy = out_valid_reg && !result_ready;
endmodule
`default_nettype wire

/* design/spiking_neuron_array_update.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spiking_neuron_array_update
// Leaky integrate-and-fire neuron array with setup, stimulus and update items.
// ----------------------------------------------------------------------------
// After reset the block sweeps its neuron state memory once, one neuron per
// cycle, with item_ready low until the sweep ends; configuration writes are
// taken during that time. Each item is then read from the state memories and
// afterwards computed and written back to them. An update whose result
// register is still full waits in the execute state until the previous
// result is transferred. Setup, stimulus, unused-op and out-of-range items
// give no result.
module spiking_neuron_array_update #(
    parameter int NODES = 1024
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [snau_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [snau_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire logic [1:0]                     op,
    input  wire logic [9:0]                     node_index,
    input  wire logic signed [23:0]             value,
    input  wire logic [31:0]                    route_path,
    input  wire logic [31:0]                    route_axon,
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output logic                                fired,
    output logic [snau_pkg::SIDE_W-1:0]         neighbor_side,
    output logic [31-snau_pkg::SIDE_W:0]        forward_path,
    output logic [31:0]                         forward_axon,
    output logic [23:0]                         forward_weight,
    output logic                                too_high
);
    import snau_pkg::*;

    snau_cmd_t    cmd;
    snau_status_t status;

    snau_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    snau_datapath #(
        .NODES (NODES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .op             (op),
        .node_index     (node_index),
        .value          (value),
        .route_path     (route_path),
        .route_axon     (route_axon),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .fired          (fired),
        .neighbor_side  (neighbor_side),
        .forward_path   (forward_path),
        .forward_axon   (forward_axon),
        .forward_weight (forward_weight),
        .too_high       (too_high)
    );
endmodule
`default_nettype wire

/* design/snau_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// snau_checker
// Port level checks of the neuron array block, bound to the top level.
// ----------------------------------------------------------------------------
module snau_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        item_valid,
    input wire logic        item_ready,
    input wire logic        result_valid,
    input wire logic        result_ready,
    input wire logic        fired,
    input wire logic [4:0]  neighbor_side,
    input wire logic [26:0] forward_path,
    input wire logic [31:0] forward_axon,
    input wire logic [23:0] forward_weight
);
    // a waiting result stays until transferred
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped before transfer");

    // one item at a time: ready drops after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken while previous item in work");

    // a result without a forward item carries zero forward fields
    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !fired |-> forward_weight == 24'd0 && forward_axon == 32'd0 &&
            neighbor_side == 5'd0 && forward_path == 27'd0)
        else $error("forward fields set without firing");

    // a new result follows the execute cycle, never the idle one
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!item_ready))
        else $error("result appeared without an item in work");
endmodule

bind spiking_neuron_array_update snau_checker u_snau_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .fired          (fired),
    .neighbor_side  (neighbor_side),
    .forward_path   (forward_path),
    .forward_axon   (forward_axon),
    .forward_weight (forward_weight)
);
`default_nettype wire

/* bench/tb_spiking_neuron_array_update.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_spiking_neuron_array_update
// Self-checking bench for the spiking neuron array update block: setup,
// stimulus, update and unused items go in under random handshake gaps over
// several register settings, each result checked against a neuron predictor.
// ----------------------------------------------------------------------------
module tb_spiking_neuron_array_update;
    import snau_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int NODE_COUNT = 1024;

    typedef struct packed {
        logic        fired;
        logic [4:0]  side;
        logic [26:0] path;
        logic [31:0] axon;
        logic [23:0] weight;
        logic        high;
    } fwd_t;

    class neuron_scoreboard;
        longint      level[NODE_COUNT];
        longint      thr[NODE_COUNT];
        longint      pot[NODE_COUNT];
        longint      refr[NODE_COUNT];
        bit          act[NODE_COUNT];
        bit          hi[NODE_COUNT];
        bit [31:0]   route[NODE_COUNT];
        bit [31:0]   axon[NODE_COUNT];
        longint      fire_pot, ticks, cool, gain;
        bit          omode;
        fwd_t        pending[$];
        int          errors, results, fires, items;

        function new();
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                level[i] = 0; thr[i] = 0; pot[i] = 0; refr[i] = 0;
                act[i] = 0; hi[i] = 0; route[i] = 0; axon[i] = 0;
            end
            fire_pot = 25600; ticks = 2; cool = 32768; gain = 256; omode = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
            case (idx)
                CFG_FIRE_POT: fire_pot = d;
                CFG_REFR:     ticks = d[7:0];
                CFG_COOL:     cool = d;
                CFG_GAIN:     gain = d;
                CFG_MODE:     omode = d[0];
                default: ;
            endcase
        endfunction

        function longint decayed(longint lv);
            longint mag;
            mag = lv < 0 ? -lv : lv;
            mag = (mag * cool) >> 16;
            return lv < 0 ? -mag : mag;
        endfunction

        function void note_item(logic [1:0] op, logic [9:0] i, logic signed [23:0] v,
                                logic [31:0] rp, logic [31:0] ra);
            longint val, lv, w;
            fwd_t r;
            val = v;
            items++;
            r = '0;
            if (op == OP_SETUP)
            begin
                thr[i] = val < 0 ? 0 : (val > THR_MAX ? THR_MAX : val);
                route[i] = rp;
                axon[i] = ra;
            end
            else if (op == OP_STIM)
            begin
                lv = level[i] + val;
                if (lv > 8388607) lv = 8388607;
                if (lv < -8388608) lv = -8388608;
                level[i] = lv;
            end
            else if (op == OP_UPDATE)
            begin
                if (omode)
                begin
                    level[i] = decayed(level[i]);
                    r.high = hi[i];
                    pending.push_back(r);
                    return;
                end
                lv = level[i];
                if (lv > LEVEL_CAP) lv = LEVEL_CAP;
                if (thr[i] <= lv && refr[i] == 0)
                begin
                    pot[i] = fire_pot; act[i] = 1; refr[i] = ticks;
                end
                else if (refr[i] == 0)
                    act[i] = 0;
                if (act[i])
                begin
                    w = (pot[i] * gain) >> 8;
                    if (w > 24'hFFFFFF) w = 24'hFFFFFF;
                    r.fired = 1;
                    r.side = route[i][4:0];
                    r.path = route[i][31:5];
                    r.axon = axon[i];
                    r.weight = 24'(w);
                end
                if (refr[i] != 0) refr[i]--;
                if (lv < 0) lv = 0;
                hi[i] = 5 * lv > 6 * thr[i];
                r.high = hi[i];
                pot[i] = (pot[i] * cool) >> 16;
                level[i] = decayed(lv);
                pending.push_back(r);
            end
        endfunction

        function void cmp(string name, longint e, longint g);
            if (e != g)
            begin
                errors++;
                $display("%0t: mismatch %s expected %0d actual %0d", $time, name, e, g);
            end
        endfunction

        function void check_result(fwd_t got);
            fwd_t e;
            results++;
            if (got.fired) fires++;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none actual %p", $time, got);
                return;
            end
            e = pending.pop_front();
            cmp("fired", e.fired, got.fired);
            cmp("neighbor_side", e.side, got.side);
            cmp("forward_path", e.path, got.path);
            cmp("forward_axon", e.axon, got.axon);
            cmp("forward_weight", e.weight, got.weight);
            cmp("too_high", e.high, got.high);
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic item_valid = 0;
    logic item_ready;
    logic [1:0] op = '0;
    logic [9:0] node_index = '0;
    logic signed [23:0] value = '0;
    logic [31:0] route_path = '0;
    logic [31:0] route_axon = '0;
    logic result_valid;
    logic result_ready = 0;
    logic fired, too_high;
    logic [SIDE_W-1:0] neighbor_side;
    logic [31-SIDE_W:0] forward_path;
    logic [31:0] forward_axon;
    logic [23:0] forward_weight;

    neuron_scoreboard sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit written[NODE_COUNT];
    int written_list[$];

    spiking_neuron_array_update dut (.*);

    always
    begin
        clk = 1; #6;
        clk = 0; #6;
    end

    always @(posedge clk)
        result_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                sb.note_item(op, node_index, value, route_path, route_axon);
            if (result_valid && result_ready)
                sb.check_result({fired, neighbor_side, forward_path, forward_axon,
                                 forward_weight, too_high});
        end
    end

    task automatic send(logic [1:0] o, logic [9:0] i, logic [23:0] v,
                        logic [31:0] rp, logic [31:0] ra);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        item_valid <= 1;
        op <= o; node_index <= i; value <= v; route_path <= rp; route_axon <= ra;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        if (o == OP_SETUP && !written[i])
        begin
            written[i] = 1;
            written_list.push_back(i);
        end
    endtask

    task automatic drain();
        item_valid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
        @(posedge clk);
        sb.set_reg(idx, d);
    endtask

    task automatic write_all(logic [15:0] fp, logic [7:0] rt, logic [15:0] cf,
                             logic [15:0] g, logic m);
        write_reg(CFG_FIRE_POT, fp);
        write_reg(CFG_REFR, {8'd0, rt});
        write_reg(CFG_COOL, cf);
        write_reg(CFG_GAIN, g);
        write_reg(CFG_MODE, {15'd0, m});
        cfg_we <= 0;
    endtask

    task automatic random_item();
        int k;
        logic [9:0] i;
        logic [23:0] v;
        k = $urandom_range(99);
        i = 10'($urandom_range(7));
        if ($urandom_range(9) == 0) i = 10'($urandom);
        if (k < 14)
        begin
            v = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(70000));
            send(OP_SETUP, i, v, $urandom, $urandom);
        end
        else if (k < 57)
        begin
            v = ($urandom_range(7) == 0) ? 24'($urandom)
                                         : 24'($signed($urandom_range(80000)) - 20000);
            send(OP_STIM, i, v, $urandom, $urandom);
        end
        else if (k < 96)
        begin
            if (!written[i])
                i = 10'(written_list[$urandom_range(written_list.size() - 1)]);
            send(OP_UPDATE, i, 24'($urandom), $urandom, $urandom);
        end
        else
            send(OP_UNUSED, 10'($urandom), 24'($urandom), $urandom, $urandom);
    endtask

    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1;
        write_all(16'd25600, 8'd2, 16'd32768, 16'd256, 1'b0);

        // directed corners
        send(OP_SETUP, 0, -24'sd5, 32'h0, 32'h0);
        send(OP_SETUP, 1, 24'h7FFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send(OP_SETUP, 2, 24'd256, 32'hA5A5A5A5, 32'h5A5A5A5A);
        for (int n = 3; n < 8; n++)
            send(OP_SETUP, 10'(n), 24'($urandom_range(30000)), $urandom, $urandom);
        send(OP_STIM, 0, 24'h7FFFFF, 0, 0);
        send(OP_STIM, 0, 24'h7FFFFF, 0, 0);
        send(OP_STIM, 1, 24'h800000, 0, 0);
        send(OP_STIM, 1, 24'h800000, 0, 0);
        send(OP_UNUSED, 3, 24'h123456, 0, 0);
        send(OP_UPDATE, 0, 0, 0, 0);
        send(OP_UPDATE, 1, 0, 0, 0);
        send(OP_UPDATE, 0, 0, 0, 0);
        send(OP_UPDATE, 0, 0, 0, 0);
        send(OP_UPDATE, 0, 0, 0, 0);
        send(OP_STIM, 2, 24'd1000, 0, 0);
        send(OP_UPDATE, 2, 0, 0, 0);
        send(OP_UPDATE, 2, 0, 0, 0);
        send(OP_SETUP, 1, 24'd300000, 32'h1F, 32'h1);
        send(OP_UPDATE, 1, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_all(16'd25600, 8'd2, 16'd32768, 16'd256, 1'b0);
                1: write_all(16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0);
                2: write_all(16'h0, 8'h0, 16'h0, 16'h0, 1'b0);
                3: write_all(16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                             1'b1);
                4: write_all(16'($urandom), 8'($urandom_range(4)), 16'($urandom),
                             16'($urandom), 1'b0);
                default: write_all(16'($urandom), 8'($urandom_range(3)), 16'($urandom),
                                   16'($urandom), 1'b0);
            endcase
            send_idle_pct = (ph == 1 || ph == 3 || ph == 5) ? ((ph == 1) ? 61 : 24) : 0;
            recv_stall_pct = (ph == 2 || ph == 3 || ph == 5) ? ((ph == 2) ? 61 : 24) : 0;
            for (int n = 0; n < 305; n++)
            begin
                random_item();
                if (ph == 1 && n == 150)
                    drain();
            end
            drain();
        end

        recv_stall_pct = 0;
        repeat (20) @(posedge clk);
        if (sb.pending.size() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
        end
        $display("covered %0d items, %0d updates checked, %0d forwards, 6 register settings",
                 sb.items, sb.results, sb.fires);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #(12 * 400000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
`default_nettype wire
